// File: src/chord_root_and_quality_unit_defines.svh
// assertion macros for the chord root and quality unit
`ifndef CHORD_ROOT_AND_QUALITY_UNIT_DEFINES_SVH
`define CHORD_ROOT_AND_QUALITY_UNIT_DEFINES_SVH

// clocked property, disabled while reset is high
`define CRQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, written against the block's own clock and reset
`define CRQ_ASSERT_CLK(label, prop, msg) \
   `CRQ_ASSERT(label, clock, reset, prop, msg)

`endif

// File: src/crq_pkg.sv
// shared types, constants and functions for the chord root and quality unit
package crq_pkg;

   localparam int PC_COUNT = 12;

   localparam int OP_W    = 1;
   localparam int SET_W   = 12;
   localparam int ROOT_W  = 4;
   localparam int PICK_W  = 8;
   localparam int QUAL_W  = 3;
   localparam int PROD_W  = PICK_W + ROOT_W;

   localparam logic [OP_W-1:0] OP_FIND_ROOT  = 1'b0;
   localparam logic [OP_W-1:0] OP_GIVEN_ROOT = 1'b1;

   localparam logic [QUAL_W-1:0] QUAL_NONE       = 3'd0;
   localparam logic [QUAL_W-1:0] QUAL_MINOR      = 3'd1;
   localparam logic [QUAL_W-1:0] QUAL_MAJOR      = 3'd2;
   localparam logic [QUAL_W-1:0] QUAL_DIMINISHED = 3'd3;
   localparam logic [QUAL_W-1:0] QUAL_AUGMENTED  = 3'd4;

   // interval distances in semitones
   localparam int IV_MIN3 = 3;
   localparam int IV_MAJ3 = 4;
   localparam int IV_DIM5 = 6;
   localparam int IV_P5   = 7;
   localparam int IV_AUG5 = 8;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [SET_W-1:0]  pitch_set;
      logic [ROOT_W-1:0] given_root;
      logic [PICK_W-1:0] pick;
   } crq_req_type;

   // index wrap for constant loop positions below two octaves of pitch classes
   function automatic int wrap12(input int v);
      return (v >= PC_COUNT) ? v - PC_COUNT : v;
   endfunction

   function automatic logic [ROOT_W-1:0] popcount12(input logic [SET_W-1:0] v);
      logic [ROOT_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < SET_W; i++) begin
         sum = sum + ROOT_W'(v[i]);
      end
      return sum;
   endfunction

   // notes with the highest third-plus-fifth score
   function automatic logic [SET_W-1:0] top_scorers(input logic [SET_W-1:0] set);
      logic [SET_W-1:0] score2;
      logic [SET_W-1:0] score1;
      logic             third;
      logic             fifth;
      score2 = '0;
      score1 = '0;
      for (int n = 0; n < PC_COUNT; n++) begin
         third     = set[wrap12(n + IV_MIN3)] | set[wrap12(n + IV_MAJ3)];
         fifth     = set[wrap12(n + IV_P5)];
         score2[n] = set[n] & third & fifth;
         score1[n] = set[n] & (third ^ fifth);
      end
      if (|score2) begin
         return score2;
      end else if (|score1) begin
         return score1;
      end
      return set;
   endfunction

   // drop candidates a third, tritone, fifth or aug fifth above another candidate, unless all would go
   function automatic logic [SET_W-1:0] filter_cands(input logic [SET_W-1:0] cand);
      logic [SET_W-1:0] kept;
      logic             drop;
      kept = '0;
      for (int c = 0; c < PC_COUNT; c++) begin
         drop = cand[wrap12(c + PC_COUNT - IV_MIN3)] |
                cand[wrap12(c + PC_COUNT - IV_MAJ3)] |
                cand[wrap12(c + PC_COUNT - IV_DIM5)] |
                cand[wrap12(c + PC_COUNT - IV_P5)]   |
                cand[wrap12(c + PC_COUNT - IV_AUG5)];
         kept[c] = cand[c] & ~drop;
      end
      return (|kept) ? kept : cand;
   endfunction

   // is the note k semitones above root sounding (root below 12)
   function automatic logic above_root(input logic [SET_W-1:0] set,
                                       input logic [ROOT_W-1:0] root,
                                       input int k);
      logic [ROOT_W:0] pos;
      pos = (ROOT_W+1)'(root) + (ROOT_W+1)'(k);
      if (pos >= (ROOT_W+1)'(PC_COUNT)) begin
         pos = pos - (ROOT_W+1)'(PC_COUNT);
      end
      return set[pos[ROOT_W-1:0]];
   endfunction

   function automatic logic [QUAL_W-1:0] chord_quality(input logic [SET_W-1:0] set,
                                                       input logic [ROOT_W-1:0] root);
      logic m3;
      logic maj3;
      logic d5;
      logic p5;
      logic a5;
      m3   = above_root(set, root, IV_MIN3);
      maj3 = above_root(set, root, IV_MAJ3);
      d5   = above_root(set, root, IV_DIM5);
      p5   = above_root(set, root, IV_P5);
      a5   = above_root(set, root, IV_AUG5);
      if (p5) begin
         return m3 ? QUAL_MINOR : (maj3 ? QUAL_MAJOR : QUAL_NONE);
      end
      if (d5)   return QUAL_DIMINISHED;
      if (a5)   return QUAL_AUGMENTED;
      if (m3)   return QUAL_MINOR;
      if (maj3) return QUAL_MAJOR;
      return QUAL_NONE;
   endfunction

endpackage

// File: src/chord_root_and_quality_unit.sv
// top level: chord root and quality finder with registered request and response
// Names the root and quality of a 12-bit pitch-class set. A request is taken on
// every clock edge where start is high; busy is never raised, so one request per
// cycle is sustained. Each response passes through the request register and then
// the response register and is shown for a single cycle with rsp_strobe high;
// the receiver must take it then, as there is no way to hold it off. In find-root
// mode (operation 0) the root comes from a third/fifth scoring of the notes, a
// filter on the top scorers and a choice among the survivors set by pick; in
// given-root mode (operation 1) the supplied root is used and candidate_set is
// zero. An empty set, or a given root of 12 or more, gives rsp_valid_res low and
// all other fields zero.
module chord_root_and_quality_unit
   import crq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [SET_W-1:0]  req_pitch_set,
   input  logic [ROOT_W-1:0] req_given_root,
   input  logic [PICK_W-1:0] req_pick,
   output logic              rsp_strobe,
   output logic              rsp_valid_res,
   output logic [ROOT_W-1:0] rsp_root_note,
   output logic [QUAL_W-1:0] rsp_quality,
   output logic [SET_W-1:0]  rsp_candidate_set
);

   // request register
   crq_req_type req_ff;
   logic        req_valid_ff;

   // response register
   logic              rsp_strobe_ff;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_ff,   rsp_root_in;
   logic [QUAL_W-1:0] rsp_qual_ff,   rsp_qual_in;
   logic [SET_W-1:0]  rsp_cands_ff,  rsp_cands_in;

   // find-root datapath
   logic [SET_W-1:0]  cands;
   logic [ROOT_W-1:0] cand_count;
   logic [PROD_W-1:0] pick_prod;
   logic [ROOT_W-1:0] pick_idx;
   logic [ROOT_W-1:0] found_root;
   logic [ROOT_W-1:0] sel_root;

   // no back pressure: the pipeline advances every cycle
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= start & ~busy;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_ff.operation  <= req_operation;
         req_ff.pitch_set  <= req_pitch_set;
         req_ff.given_root <= req_given_root;
         req_ff.pick       <= req_pick;
      end
   end

   // candidates: top scorers, then drop those stacked over another candidate
   assign cands      = filter_cands(top_scorers(req_ff.pitch_set));
   assign cand_count = popcount12(cands);

   // survivor index = (pick * count) >> 8, below count whenever count is nonzero
   assign pick_prod  = PROD_W'(req_ff.pick) * PROD_W'(cand_count);
   assign pick_idx   = pick_prod[PROD_W-1:PICK_W];

   // the selected candidate is the one with exactly pick_idx candidates below it
   always_comb begin
      logic [SET_W-1:0] below_mask;
      found_root = '0;
      for (int n = 0; n < PC_COUNT; n++) begin
         below_mask = (SET_W'(1) << n) - SET_W'(1);
         if (cands[n] && (popcount12(cands & below_mask) == pick_idx)) begin
            found_root = found_root | ROOT_W'(n);
         end
      end
   end

   // response fields
   always_comb begin
      rsp_valid_in = 1'b0;
      sel_root     = '0;
      rsp_cands_in = '0;
      if (|req_ff.pitch_set) begin
         unique case (req_ff.operation)
            OP_GIVEN_ROOT: begin
               if (req_ff.given_root < ROOT_W'(PC_COUNT)) begin
                  rsp_valid_in = 1'b1;
                  sel_root     = req_ff.given_root;
               end
            end
            OP_FIND_ROOT: begin
               rsp_valid_in = 1'b1;
               sel_root     = found_root;
               rsp_cands_in = cands;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
      rsp_root_in = sel_root;
      rsp_qual_in = rsp_valid_in ? chord_quality(req_ff.pitch_set, sel_root) : QUAL_NONE;
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_root_ff  <= rsp_root_in;
         rsp_qual_ff  <= rsp_qual_in;
         rsp_cands_ff <= rsp_cands_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_valid_res     = rsp_valid_ff;
   assign rsp_root_note     = rsp_root_ff;
   assign rsp_quality       = rsp_qual_ff;
   assign rsp_candidate_set = rsp_cands_ff;

endmodule

// File: src/crq_checker.sv
// port-level checks for the chord root and quality unit, bound to the top level
`include "chord_root_and_quality_unit_defines.svh"

module crq_checker
   import crq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic              rsp_valid_res,
   input logic [ROOT_W-1:0] rsp_root_note,
   input logic [QUAL_W-1:0] rsp_quality,
   input logic [SET_W-1:0]  rsp_candidate_set
);

   // every accepted request is followed by its response strobe
   `CRQ_ASSERT_CLK(a_rsp_follows_req, start && !busy |-> ##2 rsp_strobe, "response missing")

   // no response strobe without an earlier accepted request
   `CRQ_ASSERT_CLK(a_no_spurious_rsp, rsp_strobe |-> $past(start && !busy, 2), "spurious response")

   // an invalid response carries zero root and quality
   `CRQ_ASSERT_CLK(a_invalid_zero, rsp_strobe && !rsp_valid_res |-> rsp_root_note == '0 && rsp_quality == QUAL_NONE, "invalid response not cleared")

   // a valid root is a pitch class and, in find-root mode, one of the candidates
   `CRQ_ASSERT_CLK(a_root_in_cands, rsp_strobe && rsp_valid_res |-> rsp_root_note < ROOT_W'(PC_COUNT) && (rsp_candidate_set == '0 || rsp_candidate_set[rsp_root_note] == 1'b1), "root outside candidates")

endmodule

bind chord_root_and_quality_unit crq_checker u_crq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_valid_res     (rsp_valid_res),
   .rsp_root_note     (rsp_root_note),
   .rsp_quality       (rsp_quality),
   .rsp_candidate_set (rsp_candidate_set)
);

// File: tb/sv/tb_chord_root_and_quality_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the chord root and quality unit
module tb_chord_root_and_quality_unit;
   import crq_pkg::*;

   localparam int CLK_PERIOD  = 20;
   localparam int STALL_LIMIT = 200;   // cycles with no request or response taken
   localparam int TAIL_CYCLES = 6;     // extra cycles run after the last response is checked
   localparam int RANDOM_REQS = 700;

   // expected answer for one request
   typedef struct packed {
      logic              valid_res;
      logic [ROOT_W-1:0] root_note;
      logic [QUAL_W-1:0] quality;
      logic [SET_W-1:0]  candidate_set;
   } chord_name_type;

   // predicts the chord name of each accepted request and checks responses in order
   class chord_name_checker_type;
      chord_name_type pending_names[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      // pitch class pc sounds, pc taken modulo the octave
      function bit sounds(logic [SET_W-1:0] notes, int pc);
         return notes[pc % PC_COUNT];
      endfunction

      function chord_name_type name_chord(logic [OP_W-1:0] op, logic [SET_W-1:0] notes,
                                          logic [ROOT_W-1:0] given,
                                          logic [PICK_W-1:0] pick);
         chord_name_type   res;
         logic [SET_W-1:0] top;
         logic [SET_W-1:0] kept;
         logic [SET_W-1:0] cands;
         logic [SET_W-1:0] rel;
         logic [2*SET_W-1:0] doubled;
         int               best;
         int               score;
         int               count;
         int               slot;
         int               seen;
         res = '0;
         if (notes == '0) return res;
         if (op == OP_GIVEN_ROOT) begin
            if (given >= PC_COUNT) return res;
            res.root_note = given;
         end else begin
            // score: one point for a third above, one for a fifth above
            top  = '0;
            best = -1;
            for (int n = 0; n < PC_COUNT; n++) begin
               if (notes[n]) begin
                  score = int'(sounds(notes, n + IV_MIN3) | sounds(notes, n + IV_MAJ3)) +
                          int'(sounds(notes, n + IV_P5));
                  if (score > best) begin
                     best = score;
                     top  = '0;
                  end
                  if (score == best) top[n] = 1'b1;
               end
            end
            // drop a candidate with another one a third, tritone, fifth or aug fifth below
            kept = '0;
            for (int c = 0; c < PC_COUNT; c++) begin
               if (top[c] && !(sounds(top, c + PC_COUNT - IV_MIN3) ||
                               sounds(top, c + PC_COUNT - IV_MAJ3) ||
                               sounds(top, c + PC_COUNT - IV_DIM5) ||
                               sounds(top, c + PC_COUNT - IV_P5)   ||
                               sounds(top, c + PC_COUNT - IV_AUG5)))
                  kept[c] = 1'b1;
            end
            cands = (kept != '0) ? kept : top;
            count = $countones(cands);
            slot  = (int'(pick) * count) >> 8;
            seen  = 0;
            for (int n = 0; n < PC_COUNT; n++) begin
               if (cands[n]) begin
                  if (seen == slot) res.root_note = ROOT_W'(n);
                  seen++;
               end
            end
            res.candidate_set = cands;
         end
         res.valid_res = 1'b1;
         // bit k of rel: the note k semitones above the root sounds
         doubled = {notes, notes};
         rel     = doubled[res.root_note +: SET_W];
         if (rel[IV_P5])
            res.quality = rel[IV_MIN3] ? QUAL_MINOR : (rel[IV_MAJ3] ? QUAL_MAJOR : QUAL_NONE);
         else if (rel[IV_DIM5]) res.quality = QUAL_DIMINISHED;
         else if (rel[IV_AUG5]) res.quality = QUAL_AUGMENTED;
         else if (rel[IV_MIN3]) res.quality = QUAL_MINOR;
         else if (rel[IV_MAJ3]) res.quality = QUAL_MAJOR;
         else res.quality = QUAL_NONE;
         return res;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [SET_W-1:0] notes,
                                 logic [ROOT_W-1:0] given, logic [PICK_W-1:0] pick);
         pending_names.insert(pending_names.size(), name_chord(op, notes, given, pick));
      endfunction

      function void compare_field(string field, logic [SET_W-1:0] want, logic [SET_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         end
      endfunction

      function void check_response(logic valid_res, logic [ROOT_W-1:0] root_note,
                                   logic [QUAL_W-1:0] quality, logic [SET_W-1:0] cands);
         chord_name_type want;
         if (pending_names.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request outstanding, expected none, %s",
                     $time, "actual");
            $display("   %b/%0d/%0d/0x%0h", valid_res, root_note, quality, cands);
            return;
         end
         want = pending_names.pop_front();
         compare_field("valid_res",     SET_W'(want.valid_res), SET_W'(valid_res));
         compare_field("root_note",     SET_W'(want.root_note), SET_W'(root_note));
         compare_field("quality",       SET_W'(want.quality),   SET_W'(quality));
         compare_field("candidate_set", want.candidate_set,     cands);
      endfunction

      function int pending();
         return pending_names.size();
      endfunction
   endclass

   // every input starts from a known value; reset is high from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [OP_W-1:0]   req_operation  = OP_FIND_ROOT;
   logic [SET_W-1:0]  req_pitch_set  = '0;
   logic [ROOT_W-1:0] req_given_root = '0;
   logic [PICK_W-1:0] req_pick       = '0;
   logic              rsp_strobe;
   logic              rsp_valid_res;
   logic [ROOT_W-1:0] rsp_root_note;
   logic [QUAL_W-1:0] rsp_quality;
   logic [SET_W-1:0]  rsp_candidate_set;

   chord_name_checker_type names;
   bit                     gaps_on = 1'b1;
   int                     quiet_cycles = 0;

   chord_root_and_quality_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_pitch_set     (req_pitch_set),
      .req_given_root    (req_given_root),
      .req_pick          (req_pick),
      .rsp_strobe        (rsp_strobe),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_root_note     (rsp_root_note),
      .rsp_quality       (rsp_quality),
      .rsp_candidate_set (rsp_candidate_set)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // monitor: both channels sampled with their pre-edge values at each rising edge;
   // a response is always older than a request taken at the same edge, so check first
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_strobe)
            names.check_response(rsp_valid_res, rsp_root_note, rsp_quality, rsp_candidate_set);
         if (start && !busy)
            names.note_request(req_operation, req_pitch_set, req_given_root, req_pick);
         // watchdog: nothing taken on either side for too long means a hang
         if (rsp_strobe || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or response taken for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // present one request, hold it until the block takes it, then maybe idle a while;
   // start is only lowered when a gap follows, so back-to-back requests keep it high
   task send_request(input logic [OP_W-1:0] op, input logic [SET_W-1:0] notes,
                     input logic [ROOT_W-1:0] given, input logic [PICK_W-1:0] pick);
      req_operation  <= op;
      req_pitch_set  <= notes;
      req_given_root <= given;
      req_pick       <= pick;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      // a gap after about one request in sixteen
      if (gaps_on && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // random request, weighted toward real chords so the scoring and filter get exercised
   task send_random_request();
      logic [OP_W-1:0]    op;
      logic [SET_W-1:0]   notes;
      logic [SET_W-1:0]   shape;
      logic [2*SET_W-1:0] spun;
      logic [ROOT_W-1:0]  given;
      int                 flavor;
      op     = ($urandom_range(3) == 0) ? OP_GIVEN_ROOT : OP_FIND_ROOT;
      given  = ROOT_W'($urandom_range(15));
      flavor = $urandom_range(9);
      if (flavor <= 3) begin
         // triad or seventh on a random root, sometimes with an extra note
         case ($urandom_range(8))
            0: shape = 12'h091;   // major
            1: shape = 12'h089;   // minor
            2: shape = 12'h049;   // diminished
            3: shape = 12'h111;   // augmented
            4: shape = 12'h081;   // bare fifth
            5: shape = 12'h491;   // dominant seventh
            6: shape = 12'h489;   // minor seventh
            7: shape = 12'h891;   // major seventh
            default: shape = 12'h249;   // diminished seventh
         endcase
         spun  = {shape, shape} << $urandom_range(11);
         notes = spun[2*SET_W-1:SET_W];
         if ($urandom_range(1)) notes[$urandom_range(11)] = 1'b1;
      end else if (flavor <= 6) begin
         notes = SET_W'($urandom_range(4095));
      end else if (flavor == 7) begin
         // one or two notes
         notes = '0;
         notes[$urandom_range(11)] = 1'b1;
         if ($urandom_range(1)) notes[$urandom_range(11)] = 1'b1;
      end else if (flavor == 8) begin
         op    = OP_GIVEN_ROOT;
         notes = SET_W'($urandom_range(4095));
      end else begin
         // corners: empty or full set, or an out-of-range given root
         notes = $urandom_range(1) ? '0 : '1;
         if ($urandom_range(1)) begin
            op    = OP_GIVEN_ROOT;
            given = ROOT_W'($urandom_range(12, 15));
            notes = SET_W'($urandom_range(1, 4095));
         end
      end
      send_request(op, notes, given, PICK_W'($urandom_range(255)));
   endtask

   initial begin
      names = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty sets, single notes, full set, basic triads
      send_request(OP_FIND_ROOT,  12'h000, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h000, 4'd5,  8'd0);
      send_request(OP_FIND_ROOT,  12'h001, 4'd0,  8'd255);
      send_request(OP_FIND_ROOT,  12'h800, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'hFFF, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'hFFF, 4'd0,  8'd255);
      send_request(OP_FIND_ROOT,  12'h091, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'h089, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'h824, 4'd0,  8'd0);
      // augmented triad: every candidate would be dropped, so all stay and pick decides
      send_request(OP_FIND_ROOT,  12'h111, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'h111, 4'd0,  8'd128);
      send_request(OP_FIND_ROOT,  12'h111, 4'd0,  8'd255);
      send_request(OP_FIND_ROOT,  12'h081, 4'd0,  8'd0);
      // given root: in range, not sounding, out of range
      send_request(OP_GIVEN_ROOT, 12'h091, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h091, 4'd11, 8'd0);
      send_request(OP_GIVEN_ROOT, 12'h091, 4'd12, 8'd0);
      send_request(OP_GIVEN_ROOT, 12'hFFF, 4'd15, 8'd255);
      // each branch of the quality rule
      send_request(OP_GIVEN_ROOT, 12'h041, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h101, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h009, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h011, 4'd0,  8'd0);
      send_request(OP_GIVEN_ROOT, 12'h099, 4'd0,  8'd0);
      send_request(OP_FIND_ROOT,  12'h249, 4'd0,  8'd200);
      send_request(OP_FIND_ROOT,  12'h491, 4'd0,  8'd77);

      // random part, with a long run of back-to-back requests in the middle
      for (int i = 0; i < RANDOM_REQS; i++) begin
         gaps_on = !(i >= 250 && i < 450);
         send_random_request();
      end
      start <= 1'b0;

      // drain; the watchdog covers a response that never comes
      while (names.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (names.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/crq_pkg.sv
src/chord_root_and_quality_unit.sv
src/crq_checker.sv
tb/sv/tb_chord_root_and_quality_unit.sv
